[src/maf_pkg.sv]
// Shared types and constants for the moving average filter.
package maf_pkg;

    localparam int CFG_W      = 5;
    localparam int MEAN_W     = 24;
    localparam int INDEX_W    = 16;
    localparam int FRAC_BITS  = 8;
    localparam int MEAN_POS_LIMIT = (2 ** (MEAN_W - 1)) - 1;
    localparam int MEAN_NEG_LIMIT = 2 ** (MEAN_W - 1);

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

[src/maf_cell.sv]
// One stage of the sample delay chain with its own window tap.
module maf_cell #(
    parameter int DATA_W = 16,
    parameter int IDX_W  = 4,
    parameter int POS    = 0
) (
    input  logic              i_clk,
    input  logic              i_shift,
    input  logic [DATA_W-1:0] i_data,
    input  logic [IDX_W-1:0]  i_tap,
    output logic [DATA_W-1:0] o_data,
    output logic [DATA_W-1:0] o_tap_data
);

    logic [DATA_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data     = r_data;
    assign o_tap_data = (i_tap == IDX_W'(POS)) ? r_data : '0;

endmodule

[src/maf_div.sv]
// Bit-serial restoring divider that turns the window sum into the saturated mean.
module maf_div #(
    parameter int SUM_W = 20,
    parameter int P_W   = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_ack,
    input  logic signed [SUM_W-1:0]      i_sum,
    input  logic [P_W-1:0]               i_divisor,
    output maf_pkg::t_div_status         o_status,
    output logic signed [maf_pkg::MEAN_W-1:0] o_mean
);
    import maf_pkg::*;

    localparam int DIV_W = SUM_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam int EXT_W = (DIV_W > MEAN_W) ? DIV_W : MEAN_W + 1;

    t_div_state         r_state;
    t_div_state         n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [P_W-1:0]     r_rem;
    logic [DIV_W-1:0]   r_quo;
    logic [P_W-1:0]     r_div;
    logic               r_neg;
    logic [SUM_W-1:0]   w_mag;
    logic [P_W:0]       w_rem_shift;
    logic               w_fits;
    logic [EXT_W-1:0]   w_q_ext;
    logic [EXT_W-1:0]   w_q_neg;

    assign w_mag       = i_sum[SUM_W-1] ? (~i_sum + 1'b1) : i_sum;
    assign w_rem_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_fits      = (w_rem_shift >= {1'b0, r_div});

    always_comb begin
        n_state = r_state;
        case (r_state)
            DIV_IDLE: begin
                if (i_start) begin
                    n_state = DIV_RUN;
                end
            end
            DIV_RUN: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = DIV_DONE;
                end
            end
            DIV_DONE: begin
                if (i_ack) begin
                    n_state = DIV_IDLE;
                end
            end
            default: n_state = DIV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            DIV_IDLE: begin
                if (i_start) begin
                    r_cnt <= CNT_W'(DIV_W);
                    r_rem <= '0;
                    r_quo <= {w_mag, {FRAC_BITS{1'b0}}};
                    r_div <= i_divisor;
                    r_neg <= i_sum[SUM_W-1];
                end
            end
            DIV_RUN: begin
                r_cnt <= r_cnt - 1'b1;
                r_rem <= w_fits ? P_W'(w_rem_shift - {1'b0, r_div}) : w_rem_shift[P_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], w_fits};
            end
            default: begin
            end
        endcase
    end

    assign w_q_ext = EXT_W'(r_quo);
    assign w_q_neg = ~w_q_ext + 1'b1;

    always_comb begin
        o_status      = '0;
        o_status.busy = (r_state == DIV_RUN);
        o_status.done = (r_state == DIV_DONE);
        if (r_neg) begin
            if (w_q_ext > EXT_W'(MEAN_NEG_LIMIT)) begin
                o_mean = {1'b1, {(MEAN_W - 1){1'b0}}};
            end else begin
                o_mean = w_q_neg[MEAN_W-1:0];
            end
        end else begin
            if (w_q_ext > EXT_W'(MEAN_POS_LIMIT)) begin
                o_mean = {1'b0, {(MEAN_W - 1){1'b1}}};
            end else begin
                o_mean = w_q_ext[MEAN_W-1:0];
            end
        end
    end

endmodule

[src/moving_average_filter_unit.sv]
// Top level of the P-point moving average filter.
//
// Samples arrive on the input channel (i_sample_valid, o_sample_stall, i_sample) and are
// transferred when valid is high and stall is low. Each sample shifts into a chain of
// MAX_WINDOW delay cells and updates an exact running sum of the last P samples.
// Once P samples have been transferred since the last restart, every sample yields
// one result on the output channel (o_result_valid, i_result_stall): the mean with
// 8 fractional bits, truncated toward zero, and the sample's index since reset.
// The mean comes from a bit-serial divider. A sample that produces a result passes
// through the start register, the divider and the output register, and the input
// stalls from its transfer until the divider hands its result to the output register.
// Samples that produce no result are taken every cycle while no division is pending.
// The result sits in an output register; while the receiver stalls, the next sample
// is still taken and divided, then waits in the divider until the register frees up.
// Writing the window length through the configuration port restarts the window.
// Reset sets the window length to 1, clears the sum, fill count and sample index.
module moving_average_filter_unit #(
    parameter int MAX_WINDOW  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_sample_valid,
    output logic                                 o_sample_stall,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample,
    output logic                                 o_result_valid,
    input  logic                                 i_result_stall,
    output logic signed [maf_pkg::MEAN_W-1:0]    o_mean_value,
    output logic [maf_pkg::INDEX_W-1:0]          o_sample_index,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [maf_pkg::CFG_W-1:0]            i_cfg_data
);
    import maf_pkg::*;

    localparam int IDX_W = $clog2(MAX_WINDOW);
    localparam int P_W   = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_BITS + IDX_W;
    localparam int CMP_W = (P_W > CFG_W) ? P_W : CFG_W;

    logic [CFG_W-1:0]        r_window;
    logic [P_W-1:0]          r_fill;
    logic [P_W-1:0]          n_fill;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;
    logic [INDEX_W-1:0]      r_count;
    logic [INDEX_W-1:0]      r_pend_index;
    logic                    r_start;
    logic                    r_out_valid;
    logic signed [MEAN_W-1:0] r_out_mean;
    logic [INDEX_W-1:0]      r_out_index;

    logic [CMP_W-1:0]        w_window_ext;
    logic [P_W-1:0]          w_p;
    logic [IDX_W-1:0]        w_tap;
    logic                    w_in_xfer;
    logic                    w_cfg_xfer;
    logic                    w_full;
    logic                    w_ack;
    logic [SAMPLE_BITS-1:0]  w_chain [MAX_WINDOW+1];
    logic [SAMPLE_BITS-1:0]  w_taps  [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0]  w_oldest;
    logic signed [MEAN_W-1:0] w_mean;
    t_div_status             w_div_status;

    assign w_window_ext = CMP_W'(r_window);
    always_comb begin
        if (r_window == '0) begin
            w_p = P_W'(1);
        end else if (w_window_ext > CMP_W'(MAX_WINDOW)) begin
            w_p = P_W'(MAX_WINDOW);
        end else begin
            w_p = w_window_ext[P_W-1:0];
        end
    end
    assign w_tap = IDX_W'(w_p - 1'b1);

    assign o_cfg_ready    = 1'b1;
    assign w_cfg_xfer     = i_cfg_valid;
    assign o_sample_stall = r_start | w_div_status.busy | w_div_status.done;
    assign w_in_xfer      = i_sample_valid & ~o_sample_stall;

    assign w_chain[0] = i_sample;
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cells
        maf_cell #(
            .DATA_W(SAMPLE_BITS),
            .IDX_W (IDX_W),
            .POS   (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_shift   (w_in_xfer),
            .i_data    (w_chain[g]),
            .i_tap     (w_tap),
            .o_data    (w_chain[g+1]),
            .o_tap_data(w_taps[g])
        );
    end

    always_comb begin
        w_oldest = '0;
        for (int k = 0; k < MAX_WINDOW; k++) begin
            w_oldest = w_oldest | w_taps[k];
        end
    end

    assign w_full = (r_fill >= w_p);
    always_comb begin
        n_sum = r_sum + {{IDX_W{i_sample[SAMPLE_BITS-1]}}, i_sample};
        if (w_full) begin
            n_sum = n_sum - {{IDX_W{w_oldest[SAMPLE_BITS-1]}}, w_oldest};
        end
        n_fill = w_full ? r_fill : r_fill + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= CFG_W'(1);
            r_fill   <= '0;
            r_sum    <= '0;
            r_count  <= '0;
            r_start  <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (w_cfg_xfer) begin
                r_window <= i_cfg_data;
                r_fill   <= '0;
                r_sum    <= '0;
            end else if (w_in_xfer) begin
                r_fill  <= n_fill;
                r_sum   <= n_sum;
                r_count <= r_count + 1'b1;
                r_start <= (n_fill >= w_p);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_pend_index <= r_count;
        end
    end

    maf_div #(
        .SUM_W(SUM_W),
        .P_W  (P_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_ack    (w_ack),
        .i_sum    (r_sum),
        .i_divisor(w_p),
        .o_status (w_div_status),
        .o_mean   (w_mean)
    );

    assign w_ack = w_div_status.done & (~r_out_valid | ~i_result_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ack) begin
            r_out_valid <= 1'b1;
        end else if (~i_result_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ack) begin
            r_out_mean  <= w_mean;
            r_out_index <= r_pend_index;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_mean_value   = r_out_mean;
    assign o_sample_index = r_out_index;

endmodule

[dv/moving_average_filter_unit_tb.sv]
// Self-checking testbench for the moving average filter, with random handshakes and predicted means.
module moving_average_filter_unit_tb;

    import maf_pkg::*;

    localparam int MAX_WINDOW    = 16;
    localparam int SAMPLE_BITS   = 16;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 55;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean;
        logic [INDEX_W-1:0]       index;
    } t_window_result;

    logic                          i_clk            = 1'b0;
    logic                          i_rst_n          = 1'b0;
    logic                          i_sample_valid   = 1'b0;
    logic                          o_sample_stall;
    logic signed [SAMPLE_BITS-1:0] i_sample         = '0;
    logic                          o_result_valid;
    logic                          i_result_stall   = 1'b0;
    logic signed [MEAN_W-1:0]      o_mean_value;
    logic [INDEX_W-1:0]            o_sample_index;
    logic                          i_cfg_valid      = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_W-1:0]              i_cfg_data       = '0;

    logic signed [SAMPLE_BITS-1:0] sample_queue [$];
    t_window_result                expected_means [$];

    logic signed [SAMPLE_BITS-1:0] taps [MAX_WINDOW];
    longint                        win_sum;
    int                            fill;
    int                            wr_ptr;
    logic [INDEX_W-1:0]            next_index;
    logic [CFG_W-1:0]              win_len;

    int  samples_queued = 0;
    int  samples_sent   = 0;
    int  fail_count     = 0;
    int  src_gap        = 0;
    int  sink_gap       = 0;
    bit  quiet          = 1'b0;

    moving_average_filter_unit #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_stall (o_sample_stall),
        .i_sample       (i_sample),
        .o_result_valid (o_result_valid),
        .i_result_stall (i_result_stall),
        .o_mean_value   (o_mean_value),
        .o_sample_index (o_sample_index),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int active_length();
        if (win_len == 0) return 1;
        if (win_len > MAX_WINDOW) return MAX_WINDOW;
        return int'(win_len);
    endfunction

    function automatic void restart_window(input logic [CFG_W-1:0] len);
        win_len = len;
        foreach (taps[i]) taps[i] = '0;
        win_sum = 0;
        fill    = 0;
        wr_ptr  = 0;
    endfunction

    function automatic void average_step(input logic signed [SAMPLE_BITS-1:0] x);
        int             p;
        int             oldest;
        t_window_result r;
        p = active_length();
        r.index = next_index;
        next_index++;
        if (fill >= p) begin
            oldest = (wr_ptr + MAX_WINDOW - p) % MAX_WINDOW;
            win_sum -= taps[oldest];
        end
        taps[wr_ptr] = x;
        win_sum += x;
        wr_ptr = (wr_ptr + 1) % MAX_WINDOW;
        if (fill < p) fill++;
        if (fill >= p) begin
            r.mean = MEAN_W'((win_sum * 256) / p);
            expected_means.push_back(r);
        end
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Sample source: holds the payload while stalled, inserts idle bursts between transfers.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_sample_valid <= 1'b0;
        end else if (!i_sample_valid || !o_sample_stall) begin
            if (src_gap > 0) begin
                src_gap--;
                i_sample_valid <= 1'b0;
            end else if (sample_queue.size() == 0) begin
                i_sample_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                src_gap = $urandom_range(0, 9);
                i_sample_valid <= 1'b0;
            end else begin
                i_sample       <= sample_queue.pop_front();
                i_sample_valid <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_result_stall <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            i_result_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            sink_gap = $urandom_range(0, 9);
            i_result_stall <= 1'b1;
        end else begin
            i_result_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_window_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) restart_window(i_cfg_data);
            if (i_sample_valid && !o_sample_stall) begin
                average_step(i_sample);
                samples_sent++;
            end
            if (o_result_valid && !i_result_stall) begin
                if (expected_means.size() == 0) begin
                    $error("unexpected result: mean_value %0d, sample_index %0d",
                           o_mean_value, o_sample_index);
                    fail_count++;
                end else begin
                    want = expected_means.pop_front();
                    if (o_mean_value !== want.mean) begin
                        $error("mean_value: expected %0d, got %0d", want.mean, o_mean_value);
                        fail_count++;
                    end
                    if (o_sample_index !== want.index) begin
                        $error("sample_index: expected %0d, got %0d",
                               want.index, o_sample_index);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] x);
        sample_queue.push_back(x);
        samples_queued++;
    endtask

    // Drain a little longer after the last predicted result, so that any unexpected result still shows.
    task automatic settle();
        while (samples_sent != samples_queued || expected_means.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] len);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CFG_W-1:0] first_lengths [5];
        first_lengths = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd17};
        restart_window(5'd1);
        next_index = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_sample(16'sh7FFF);
        push_sample(16'sh8000);
        push_sample(16'sh0000);
        push_sample(-16'sd1);
        push_sample(16'sd1);
        settle();

        write_window(5'd0);
        push_sample(16'sh8000);
        push_sample(16'sh7FFF);
        push_sample(-16'sd1);
        settle();

        write_window(5'd16);
        repeat (16) push_sample(16'sh8000);
        push_sample(16'sh7FFF);
        settle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == RANDOM_PHASES - 1) quiet = 1'b1;
            write_window(ph < 5 ? first_lengths[ph] : CFG_W'($urandom_range(0, 31)));
            repeat (PHASE_ITEMS) push_sample(random_sample());
            settle();
        end

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

[files.f]
src/maf_pkg.sv
src/maf_cell.sv
src/maf_div.sv
src/moving_average_filter_unit.sv
dv/moving_average_filter_unit_tb.sv
